### rtl/nkzl_pkg.sv
`default_nettype none
package nkzl_pkg;

  // Field widths
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned ZONE_W   = 10;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KCFG_W   = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  // Parameter defaults
  localparam int unsigned MAX_K_DEF     = 8;
  localparam int unsigned MAX_ZONES_DEF = 1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_K_IN_USE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT = 1'd1;

  // Register reset values
  localparam logic [KCFG_W-1:0] K_IN_USE_RST   = 4'd8;
  localparam logic [DIST_W-1:0] DIST_LIMIT_RST = 16'hFFFF;

endpackage
`default_nettype wire

### rtl/nkzl_cmp_unit.sv
`default_nettype none
// Shared compare unit: judges one stored entry against the candidate
// and the running farthest distance.
module nkzl_cmp_unit
  import nkzl_pkg::*;
(
  input  wire logic              entry_valid_i,
  input  wire logic [DIST_W-1:0] entry_dist_i,
  input  wire logic [DIST_W-1:0] cand_dist_i,
  input  wire logic [DIST_W-1:0] far_dist_i,
  output logic                   is_empty_o,
  output logic                   is_farther_o,
  output logic                   is_closer_o
);

  assign is_empty_o   = ~entry_valid_i;
  assign is_farther_o = entry_dist_i > far_dist_i;
  assign is_closer_o  = cand_dist_i < entry_dist_i;

endmodule
`default_nettype wire

### rtl/nearest_k_zone_list.sv
`default_nettype none
// Nearest-K zone list. Holds an unordered list of up to MAX_K (zone,
// distance) entries for one pixel; distances are unsigned Q12.4. Each
// transfer on the input stream carries one operation in tuser: clear empties
// the list, offer proposes a candidate, read returns one slot. Every
// operation yields exactly one result transfer. An offer below
// distance_limit with a zone below MAX_ZONES fills the first empty slot among
// the first k_in_use slots, or else replaces the farthest entry (first one on
// ties) when the candidate is closer than some held entry. Timing: the block
// takes one item at a time. Clear, read, nop and a refused offer go
// straight to the finish state; an offer that goes to the scan visits
// slots up to k_in_use first, and when all are full also notes the end
// of the list. The scan visits one slot per cycle through a single shared
// compare unit. The finish state waits until the output register is free.
// A new item is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register.
// Configuration: write k_in_use (index 0) and distance_limit (index 1) only
// while the block is idle.
module nearest_k_zone_list
  import nkzl_pkg::*;
#(
  parameter int unsigned MAX_K     = MAX_K_DEF,
  parameter int unsigned MAX_ZONES = MAX_ZONES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: cand_distance[15:0], cand_zone[25:16], read_slot[28:26], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode[1:0]
  input  wire logic [OP_W-1:0]       s_axis_tuser,

  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: accepted[0], slot_valid[1], slot_distance[17:2],
  //        slot_zone[27:18], zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_K + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Configuration registers
  logic [KCFG_W-1:0] k_q;
  logic [DIST_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= K_IN_USE_RST;
      limit_q <= DIST_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_K_IN_USE:   k_q     <= cfg_data_i[KCFG_W-1:0];
        REG_DIST_LIMIT: limit_q <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Slots in use, saturated to MAX_K
  logic [31:0]      k_ext;
  logic [31:0]      n_ext;
  logic [CNT_W-1:0] n_slots;

  assign k_ext   = 32'(k_q);
  assign n_ext   = (k_ext > MAX_K) ? MAX_K : k_ext;
  assign n_slots = n_ext[CNT_W-1:0];

  // Input field split
  logic [DIST_W-1:0] in_dist;
  logic [ZONE_W-1:0] in_zone;
  logic [SLOT_W-1:0] in_slot;

  assign in_dist = s_axis_tdata[DIST_W-1:0];
  assign in_zone = s_axis_tdata[DIST_W+ZONE_W-1:DIST_W];
  assign in_slot = s_axis_tdata[DIST_W+ZONE_W+SLOT_W-1:DIST_W+ZONE_W];

  // Item and scan registers
  logic [1:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [DIST_W-1:0] cand_dist_q, cand_dist_d;
  logic [ZONE_W-1:0] cand_zone_q, cand_zone_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIST_W-1:0] far_q, far_d;
  logic [IDX_W-1:0]  target_q, target_d;
  logic              take_q, take_d;

  // List storage; payload needs no reset since invalid slots read as zero
  logic              valid_q [MAX_K];
  logic [DIST_W-1:0] dist_q  [MAX_K];
  logic [ZONE_W-1:0] zone_q  [MAX_K];

  // Output register
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  // Single read index: read slot for a read, scan counter otherwise
  logic [31:0]       slot_ext;
  logic              slot_in_range;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_valid;
  logic [DIST_W-1:0] rd_dist;
  logic [ZONE_W-1:0] rd_zone;

  assign slot_ext      = 32'(slot_q);
  assign slot_in_range = slot_ext < MAX_K;
  assign rd_idx        = (op_q == OP_READ) ? slot_ext[IDX_W-1:0] : cnt_q[IDX_W-1:0];
  assign rd_valid      = valid_q[rd_idx];
  assign rd_dist       = dist_q[rd_idx];
  assign rd_zone       = zone_q[rd_idx];

  logic is_empty, is_farther, is_closer;

  nkzl_cmp_unit u_cmp (
    .entry_valid_i (rd_valid),
    .entry_dist_i  (rd_dist),
    .cand_dist_i   (cand_dist_q),
    .far_dist_i    (far_q),
    .is_empty_o    (is_empty),
    .is_farther_o  (is_farther),
    .is_closer_o   (is_closer)
  );

  logic in_xfer;
  logic out_free;
  logic refuse;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign refuse        = (in_dist >= limit_q) || (32'(in_zone) >= MAX_ZONES);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cand_dist_d = cand_dist_q;
    cand_zone_d = cand_zone_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    far_d       = far_q;
    target_d    = target_q;
    take_d      = take_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d        = s_axis_tuser;
          cand_dist_d = in_dist;
          cand_zone_d = in_zone;
          slot_d      = in_slot;
          cnt_d       = '0;
          far_d       = '0;
          target_d    = '0;
          take_d      = 1'b0;
          // Refused offers skip the scan
          state_d = (s_axis_tuser == OP_OFFER && !refuse) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (cnt_q >= n_slots) begin
          state_d = ST_FIN;
        end else if (is_empty) begin
          take_d   = 1'b1;
          target_d = cnt_q[IDX_W-1:0];
          state_d  = ST_FIN;
        end else begin
          if (is_farther) begin
            far_d    = rd_dist;
            target_d = cnt_q[IDX_W-1:0];
          end
          if (is_closer) begin
            take_d = 1'b1;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result assembly
  logic              res_accepted;
  logic              res_valid;
  logic [DIST_W-1:0] res_dist;
  logic [ZONE_W-1:0] res_zone;
  logic              fin_load;

  assign fin_load     = (state_q == ST_FIN) && out_free;
  assign res_accepted = (op_q == OP_OFFER) && take_q;
  assign res_valid    = (op_q == OP_READ) && slot_in_range && rd_valid;
  assign res_dist     = res_valid ? rd_dist : '0;
  assign res_zone     = res_valid ? rd_zone : '0;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (fin_load) begin
      m_valid_d = 1'b1;
      m_data_d  = OUT_DATA_W'({res_zone, res_dist, res_valid, res_accepted});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      take_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      take_q    <= take_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    cand_dist_q <= cand_dist_d;
    cand_zone_q <= cand_zone_d;
    slot_q      <= slot_d;
    far_q       <= far_d;
    target_q    <= target_d;
    m_data_q    <= m_data_d;
  end

  // Valid bits: drop all on clear, set the target on an accepted offer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_K; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (fin_load && op_q == OP_CLEAR) begin
      for (int i = 0; i < MAX_K; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (fin_load && res_accepted) begin
      valid_q[target_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load && res_accepted) begin
      dist_q[target_q] <= cand_dist_q;
      zone_q[target_q] <= cand_zone_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire
